@@ hdl/wfa_pkg.sv @@
// Shared types, codes and timing constants for the frame airtime block.
package wfa_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SUM,
		ST_OUT
	} wfa_state_t;

	typedef logic [1:0] ac_t;

	localparam int LEN_WIDTH_DEF = 12;
	localparam int RATE_W        = 10;
	localparam int DUR_W         = 16;
	localparam int GAP_W         = 15;

	localparam logic [1:0] MODE_B = 2'd0;
	localparam logic [1:0] MODE_G = 2'd1;
	localparam logic [1:0] MODE_A = 2'd2;

	localparam logic [2:0] KIND_CTS    = 3'd0;
	localparam logic [2:0] KIND_ACK    = 3'd1;
	localparam logic [2:0] KIND_BEACON = 3'd2;
	localparam logic [2:0] KIND_QOS    = 3'd3;
	localparam logic [2:0] KIND_DATA   = 3'd4;

	// CCK rates, in 100 kbps units, that keep an 11g frame on CCK
	localparam logic [RATE_W-1:0] RATE_1M  = 10'd10;
	localparam logic [RATE_W-1:0] RATE_2M  = 10'd20;
	localparam logic [RATE_W-1:0] RATE_5M5 = 10'd55;
	localparam logic [RATE_W-1:0] RATE_11M = 10'd110;

	localparam logic [4:0] SIFS_OFDM  = 5'd16;
	localparam logic [4:0] SIFS_CCK   = 5'd10;
	localparam logic [4:0] SLOT_SHORT = 5'd9;
	localparam logic [4:0] SLOT_LONG  = 5'd20;
	localparam logic [7:0] PRE_LONG   = 8'd192;
	localparam logic [7:0] PRE_SHORT  = 8'd96;
	localparam logic [7:0] OFDM_HDR   = 8'd20;
	localparam logic [4:0] OFDM_EXTRA = 5'd22;
	localparam logic [2:0] DIFS_SLOTS = 3'd2;
	localparam logic [3:0] CW_MIN_DEF = 4'd4;
	localparam logic [3:0] CW_MAX_DEF = 4'd10;

	localparam ac_t        UP_TO_AC [8] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3};
	localparam logic [2:0] AC_AIFS  [4] = '{3'd3, 3'd7, 3'd2, 3'd2};
	localparam logic [3:0] AC_CWMIN [4] = '{4'd4, 4'd4, 4'd3, 4'd2};
	localparam logic [3:0] AC_CWMAX [4] = '{4'd10, 4'd10, 4'd4, 4'd3};

endpackage

@@ hdl/wlan_frame_airtime_core.sv @@
// Frame airtime calculator: transmit time by shared restoring divider plus gap and contention.
//
// The request channel (req_valid/req_ready) carries one frame description a beat:
// PHY mode, length, rate, preamble and slot flags, frame kind, priority and retries.
// The result channel (res_valid/res_ready) returns one beat per request with the
// airtime in microseconds and a rate error flag.
// The transmit time needs a ceiling division of the bit count by the rate. One
// restoring subtract-and-shift unit produces a quotient bit a cycle; a sum state
// then adds the preamble or OFDM header and the gap and registers the result.
// A zero rate skips the divider: the result is valid in the cycle after the request.
// The block takes one frame at a time; req_ready rises again the cycle after the
// result beat is taken, so a new frame cannot start before the last result is taken.
// While res_ready is low the result holds and no request is taken.
// Reset returns the sequencer to idle and clears the "last frame was a CTS" flag.
module wlan_frame_airtime_core #(
	parameter int LEN_WIDTH = wfa_pkg::LEN_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [1:0]                  phy_mode,
	input  logic [LEN_WIDTH-1:0]        frame_len,
	input  logic [wfa_pkg::RATE_W-1:0]  rate,
	input  logic                        short_plcp,
	input  logic                        short_slot,
	input  logic [2:0]                  frame_kind,
	input  logic [2:0]                  priority_req,
	input  logic [3:0]                  retry_count,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [wfa_pkg::DUR_W-1:0]   duration_us,
	output logic                        rate_error
);
	import wfa_pkg::*;

	localparam int NUM_W = LEN_WIDTH + 7;
	localparam int DIV_W = RATE_W + 2;
	localparam int CNT_W = $clog2(NUM_W);
	localparam int SUM_W = NUM_W + 3;

	wfa_state_t state_q, state_nxt;

	logic [CNT_W-1:0] cnt_q;
	logic             prev_cts_q;
	logic [NUM_W-1:0] num_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [GAP_W-1:0] gap_q;
	logic [7:0]       pre_q;
	logic             ofdm_q;
	logic [DUR_W-1:0] dur_q;
	logic             err_q;

	logic             req_beat;
	logic             res_beat;
	logic             rate_zero;
	logic             ofdm;
	logic [LEN_WIDTH:0]   bytes4;
	logic [NUM_W-1:0]     bits;
	logic [NUM_W-1:0]     bits10;
	logic [DIV_W-1:0]     divisor;
	logic [NUM_W-1:0]     numer;
	logic [4:0]       sifs;
	logic [4:0]       slot;
	ac_t              ac;
	logic [3:0]       cwmin;
	logic [3:0]       cwmax;
	logic [4:0]       cw_exp_raw;
	logic [3:0]       cw_exp;
	logic [10:0]      cw_pow;
	logic [9:0]       cw;
	logic [14:0]      cw_slot;
	logic [GAP_W-1:0] cw_time;
	logic [2:0]       aifs;
	logic [GAP_W-1:0] gap;

	logic [DIV_W:0]   trial;
	logic             trial_ge;
	logic [SUM_W-1:0] sum;

	assign req_beat  = req_valid && req_ready;
	assign res_beat  = res_valid && res_ready;
	assign rate_zero = (rate == '0);

	// Load datapath: bit count, divisor and gap of the incoming frame
	always_comb begin
		ofdm = (phy_mode == MODE_A) ||
		       ((phy_mode == MODE_G) && (rate != RATE_1M) && (rate != RATE_2M) &&
		        (rate != RATE_5M5) && (rate != RATE_11M));
		bytes4  = {1'b0, frame_len} + (LEN_WIDTH+1)'(4);
		bits    = NUM_W'({bytes4, 3'b000}) + (ofdm ? NUM_W'(OFDM_EXTRA) : '0);
		bits10  = (bits << 3) + (bits << 1);
		divisor = ofdm ? {rate, 2'b00} : {2'b00, rate};
		// ceiling division: bias the dividend by divisor - 1
		numer   = bits10 + NUM_W'(divisor) - NUM_W'(1);

		sifs = ofdm ? SIFS_OFDM : SIFS_CCK;
		slot = (ofdm || short_slot) ? SLOT_SHORT : SLOT_LONG;
		ac   = UP_TO_AC[priority_req];

		if (frame_kind == KIND_QOS) begin
			cwmin = AC_CWMIN[ac];
			cwmax = AC_CWMAX[ac];
			aifs  = AC_AIFS[ac];
		end else begin
			cwmin = CW_MIN_DEF;
			cwmax = CW_MAX_DEF;
			aifs  = DIFS_SLOTS;
		end
		cw_exp_raw = {1'b0, cwmin} + {1'b0, retry_count};
		cw_exp     = (cw_exp_raw > {1'b0, cwmax}) ? cwmax : cw_exp_raw[3:0];
		cw_pow     = 11'd1 << cw_exp;
		cw         = 10'(cw_pow - 11'd1);
		cw_slot    = 15'(cw) * 15'(slot);
		cw_time    = GAP_W'(cw_slot >> 1);

		case (frame_kind) inside
			KIND_CTS, KIND_ACK: begin
				gap = GAP_W'(sifs);
			end
			KIND_BEACON: begin
				gap = GAP_W'(sifs) + GAP_W'({slot, 1'b0}) + GAP_W'(slot >> 1);
			end
			KIND_QOS, KIND_DATA: begin
				if (prev_cts_q) begin
					gap = GAP_W'(sifs);
				end else begin
					gap = GAP_W'(sifs) + GAP_W'(aifs) * GAP_W'(slot) + cw_time;
				end
			end
			default: begin
				gap = GAP_W'(sifs) + GAP_W'(aifs) * GAP_W'(slot) + cw_time;
			end
		endcase
	end

	// One restoring divide step: shift in a dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, num_q[NUM_W-1]};
		trial_ge = (trial >= {1'b0, div_q});
	end

	always_comb begin
		if (ofdm_q) begin
			sum = SUM_W'(OFDM_HDR) + SUM_W'({num_q, 2'b00}) + SUM_W'(gap_q);
		end else begin
			sum = SUM_W'(pre_q) + SUM_W'(num_q) + SUM_W'(gap_q);
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_beat) begin
					state_nxt = rate_zero ? ST_OUT : ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = ST_SUM;
				end
			end
			ST_SUM: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (res_beat) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Handshake outputs
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_OUT:  res_valid = 1'b1;
			default: begin
				req_ready = 1'b0;
				res_valid = 1'b0;
			end
		endcase
	end

	assign duration_us = dur_q;
	assign rate_error  = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			prev_cts_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (req_beat) begin
				cnt_q <= CNT_W'(NUM_W - 1);
				// a zero rate leaves the CTS flag alone
				if (!rate_zero) begin
					prev_cts_q <= (frame_kind == KIND_CTS);
				end
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_beat) begin
			num_q  <= numer;
			rem_q  <= '0;
			div_q  <= divisor;
			gap_q  <= gap;
			pre_q  <= short_plcp ? PRE_SHORT : PRE_LONG;
			ofdm_q <= ofdm;
			dur_q  <= '0;
			err_q  <= rate_zero;
		end else if (state_q == ST_DIV) begin
			num_q <= {num_q[NUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
		end else if (state_q == ST_SUM) begin
			// saturate long airtimes
			dur_q <= (sum > SUM_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}} : sum[DUR_W-1:0];
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the frame airtime calculator.
`timescale 1ns / 1ps

module tb_top;
	import wfa_pkg::*;

	localparam logic [1:0]        MODE_SPARE  = 2'd3;
	localparam logic [2:0]        KIND_OTHER  = 3'd5;
	localparam logic [2:0]        KIND_SPARE6 = 3'd6;
	localparam logic [2:0]        KIND_SPARE7 = 3'd7;
	localparam logic [RATE_W-1:0] RATE_NONE   = '0;
	localparam logic [RATE_W-1:0] RATE_MAX    = '1;

	localparam int unsigned PRIO_TO_AC [8] = '{0, 1, 1, 0, 2, 2, 3, 3};
	localparam int unsigned AIFS_SLOTS [4] = '{3, 7, 2, 2};
	localparam int unsigned CW_LOW     [4] = '{4, 4, 3, 2};
	localparam int unsigned CW_HIGH    [4] = '{10, 10, 4, 3};
	localparam int unsigned OFDM_RATES [8] = '{60, 90, 120, 180, 240, 360, 480, 540};
	localparam int unsigned CCK_RATES  [4] = '{10, 20, 55, 110};

	localparam int N_RANDOM       = 600;
	localparam int HOLD_AFTER     = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct packed {
		logic [1:0]        phy_mode;
		logic [11:0]       frame_len;
		logic [RATE_W-1:0] rate;
		logic              short_plcp;
		logic              short_slot;
		logic [2:0]        frame_kind;
		logic [2:0]        priority_req;
		logic [3:0]        retry_count;
	} frame_t;

	typedef struct packed {
		logic [DUR_W-1:0] duration_us;
		logic             rate_error;
	} airtime_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic [1:0]        phy_mode = '0;
	logic [11:0]       frame_len = '0;
	logic [RATE_W-1:0] rate = '0;
	logic              short_plcp = 1'b0;
	logic              short_slot = 1'b0;
	logic [2:0]        frame_kind = '0;
	logic [2:0]        priority_req = '0;
	logic [3:0]        retry_count = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	logic [DUR_W-1:0]  duration_us;
	logic              rate_error;

	frame_t   frame_backlog [$];
	airtime_t airtime_due [$];
	frame_t   cur_frame;
	bit       cts_seen;
	int       frames_total;
	int       beats_in;
	int       beats_out;
	int       hold_left;
	int       quiet_cycles;
	int       mismatches;

	wlan_frame_airtime_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.phy_mode       (phy_mode),
		.frame_len      (frame_len),
		.rate           (rate),
		.short_plcp     (short_plcp),
		.short_slot     (short_slot),
		.frame_kind     (frame_kind),
		.priority_req   (priority_req),
		.retry_count    (retry_count),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.duration_us    (duration_us),
		.rate_error     (rate_error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned backoff_us(int unsigned cw_lo, int unsigned cw_hi,
			int unsigned retries, int unsigned slot);
		int unsigned cw;
		int unsigned cap;
		cw = (32'd1 << (cw_lo + retries)) - 1;
		cap = (32'd1 << cw_hi) - 1;
		if (cw > cap)
			cw = cap;
		return (cw * slot) / 2;
	endfunction

	function automatic airtime_t predict_airtime(frame_t f, bit after_cts);
		int unsigned len;
		int unsigned bits10;
		int unsigned step;
		int unsigned sifs;
		int unsigned slot;
		int unsigned total;
		int unsigned ac;
		bit          ofdm;
		airtime_t    r;
		r.rate_error = 1'b0;
		if (f.rate == RATE_NONE) begin
			r.duration_us = '0;
			r.rate_error = 1'b1;
			return r;
		end
		len = f.frame_len;
		ofdm = (f.phy_mode == MODE_A) || (f.phy_mode == MODE_G && f.rate != RATE_1M &&
			f.rate != RATE_2M && f.rate != RATE_5M5 && f.rate != RATE_11M);
		if (ofdm) begin
			bits10 = (16 + 8 * (len + 4) + 6) * 10;
			step = 4 * f.rate;
			sifs = 16;
			slot = 9;
			total = 20 + 4 * ((bits10 + step - 1) / step);
		end else begin
			bits10 = 8 * (len + 4) * 10;
			sifs = 10;
			slot = f.short_slot ? 9 : 20;
			total = f.short_plcp ? 96 : 192;
			total += (bits10 + f.rate - 1) / f.rate;
		end
		if (f.frame_kind == KIND_CTS || f.frame_kind == KIND_ACK) begin
			total += sifs;
		end else if (f.frame_kind == KIND_BEACON) begin
			total += sifs + 2 * slot + slot / 2;
		end else if ((f.frame_kind == KIND_QOS || f.frame_kind == KIND_DATA) && after_cts) begin
			total += sifs;
		end else if (f.frame_kind == KIND_QOS) begin
			ac = PRIO_TO_AC[f.priority_req];
			total += sifs + AIFS_SLOTS[ac] * slot;
			total += backoff_us(CW_LOW[ac], CW_HIGH[ac], f.retry_count, slot);
		end else begin
			total += sifs + 2 * slot + backoff_us(4, 10, f.retry_count, slot);
		end
		if (total > 32'hFFFF)
			total = 32'hFFFF;
		r.duration_us = total[DUR_W-1:0];
		return r;
	endfunction

	task automatic add_frame(logic [1:0] mode, logic [11:0] len, logic [RATE_W-1:0] rt,
			logic spre, logic sslot, logic [2:0] kind, logic [2:0] prio, logic [3:0] retries);
		frame_t f;
		f.phy_mode = mode;
		f.frame_len = len;
		f.rate = rt;
		f.short_plcp = spre;
		f.short_slot = sslot;
		f.frame_kind = kind;
		f.priority_req = prio;
		f.retry_count = retries;
		frame_backlog.push_back(f);
	endtask

	task automatic add_random_frame(logic [2:0] kind);
		logic [1:0]        mode;
		logic [11:0]       len;
		logic [RATE_W-1:0] rt;
		int                pick;
		mode = ($urandom_range(0, 15) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
		len = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 64)) : 12'($urandom);
		pick = $urandom_range(0, 19);
		if (pick == 0)
			rt = RATE_NONE;
		else if (pick < 5)
			rt = RATE_W'($urandom_range(1, 1023));
		else if (mode == MODE_B || mode == MODE_SPARE || pick < 9)
			rt = RATE_W'(CCK_RATES[$urandom_range(0, 3)]);
		else
			rt = RATE_W'(OFDM_RATES[$urandom_range(0, 7)]);
		add_frame(mode, len, rt, 1'($urandom), 1'($urandom), kind, 3'($urandom),
			4'($urandom));
	endtask

	function automatic int sender_idle_pct(int done, int total);
		if (done * 3 < total)
			return 33;
		else if (done * 3 < total * 2)
			return 77;
		return 0;
	endfunction

	function automatic int receiver_idle_pct(int done, int total);
		if (done * 3 < total)
			return 77;
		else if (done * 3 < total * 2)
			return 33;
		return 0;
	endfunction

	// request side: offer the backlog and predict each accepted beat
	always @(posedge clk or negedge arst_n) begin
		bit offer;
		if (!arst_n) begin
			req_valid <= 1'b0;
			cts_seen = 1'b0;
			beats_in <= 0;
		end else begin
			offer = req_valid;
			if (req_valid && req_ready) begin
				airtime_due.push_back(predict_airtime(cur_frame, cts_seen));
				if (cur_frame.rate != RATE_NONE)
					cts_seen = (cur_frame.frame_kind == KIND_CTS);
				beats_in <= beats_in + 1;
				offer = 1'b0;
			end
			if (!offer && frame_backlog.size() > 0 &&
					$urandom_range(0, 99) >= sender_idle_pct(beats_in, frames_total)) begin
				cur_frame = frame_backlog.pop_front();
				phy_mode <= cur_frame.phy_mode;
				frame_len <= cur_frame.frame_len;
				rate <= cur_frame.rate;
				short_plcp <= cur_frame.short_plcp;
				short_slot <= cur_frame.short_slot;
				frame_kind <= cur_frame.frame_kind;
				priority_req <= cur_frame.priority_req;
				retry_count <= cur_frame.retry_count;
				offer = 1'b1;
			end
			req_valid <= offer;
		end
	end

	// result side: check each beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		airtime_t want;
		bit       take;
		if (!arst_n) begin
			res_ready <= 1'b0;
			beats_out <= 0;
			hold_left = 0;
			mismatches = 0;
		end else begin
			if (res_valid && res_ready) begin
				beats_out <= beats_out + 1;
				// hold off once so the block fills and stalls its request side
				if (beats_out + 1 == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
				if (airtime_due.size() == 0) begin
					$display("%0t: result with none due: duration_us %0d rate_error %0b",
						$time, duration_us, rate_error);
					mismatches++;
				end else begin
					want = airtime_due.pop_front();
					if (duration_us !== want.duration_us) begin
						$display("%0t: duration_us expected %0d actual %0d",
							$time, want.duration_us, duration_us);
						mismatches++;
					end
					if (rate_error !== want.rate_error) begin
						$display("%0t: rate_error expected %0b actual %0b",
							$time, want.rate_error, rate_error);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				take = $urandom_range(0, 99) >= receiver_idle_pct(beats_out, frames_total);
			end
			res_ready <= take;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		int n;
		quiet_cycles = 0;
		// field extremes, every mode and kind, zero rate and the after-CTS rule
		add_frame(MODE_B, 12'd0, RATE_1M, 1'b0, 1'b0, KIND_DATA, 3'd0, 4'd0);
		add_frame(MODE_B, 12'd4095, 10'd1, 1'b0, 1'b0, KIND_ACK, 3'd0, 4'd0);
		add_frame(MODE_A, 12'd4095, 10'd1, 1'b0, 1'b0, KIND_OTHER, 3'd0, 4'd15);
		add_frame(MODE_A, 12'd0, RATE_MAX, 1'b1, 1'b1, KIND_BEACON, 3'd7, 4'd15);
		add_frame(MODE_G, 12'd100, RATE_1M, 1'b1, 1'b1, KIND_CTS, 3'd0, 4'd0);
		add_frame(MODE_G, 12'd100, RATE_NONE, 1'b0, 1'b0, KIND_ACK, 3'd0, 4'd0);
		add_frame(MODE_G, 12'd1500, RATE_11M, 1'b0, 1'b0, KIND_QOS, 3'd6, 4'd2);
		add_frame(MODE_G, 12'd200, RATE_2M, 1'b0, 1'b1, KIND_DATA, 3'd0, 4'd1);
		add_frame(MODE_G, 12'd300, RATE_5M5, 1'b1, 1'b0, KIND_QOS, 3'd1, 4'd15);
		add_frame(MODE_G, 12'd64, 10'd540, 1'b0, 1'b0, KIND_QOS, 3'd2, 4'd3);
		add_frame(MODE_A, 12'd512, 10'd60, 1'b0, 1'b0, KIND_QOS, 3'd0, 4'd0);
		add_frame(MODE_A, 12'd512, 10'd60, 1'b0, 1'b0, KIND_QOS, 3'd3, 4'd15);
		add_frame(MODE_A, 12'd512, 10'd90, 1'b0, 1'b0, KIND_QOS, 3'd4, 4'd1);
		add_frame(MODE_A, 12'd512, 10'd120, 1'b0, 1'b0, KIND_QOS, 3'd5, 4'd15);
		add_frame(MODE_A, 12'd512, 10'd240, 1'b0, 1'b0, KIND_QOS, 3'd7, 4'd15);
		add_frame(MODE_SPARE, 12'd77, RATE_11M, 1'b0, 1'b1, KIND_SPARE6, 3'd0, 4'd4);
		add_frame(MODE_B, 12'd33, RATE_5M5, 1'b1, 1'b0, KIND_SPARE7, 3'd0, 4'd15);
		add_frame(MODE_A, 12'd14, 10'd480, 1'b0, 1'b0, KIND_CTS, 3'd0, 4'd0);
		add_frame(MODE_A, 12'd1000, 10'd480, 1'b0, 1'b0, KIND_DATA, 3'd0, 4'd9);
		add_frame(MODE_A, 12'd1000, 10'd480, 1'b0, 1'b0, KIND_DATA, 3'd0, 4'd9);
		add_frame(MODE_SPARE, 12'd4095, RATE_NONE, 1'b1, 1'b1, KIND_SPARE7, 3'd7, 4'd15);
		n = 0;
		while (n < N_RANDOM) begin
			if ($urandom_range(0, 3) == 0) begin
				add_random_frame(KIND_CTS);
				add_random_frame($urandom_range(0, 1) ? KIND_QOS : KIND_DATA);
				n += 2;
			end else begin
				add_random_frame(3'($urandom));
				n++;
			end
		end
		frames_total = frame_backlog.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (!(frame_backlog.size() == 0 && !req_valid && airtime_due.size() == 0) &&
			quiet_cycles < WATCHDOG_LIMIT);

		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (mismatches == 0 && airtime_due.size() == 0)
				$display("PASS");
			else
				$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/wfa_pkg.sv
hdl/wlan_frame_airtime_core.sv
tb/tb_top.sv
